// File: rtl/core/led_seq_pkg.sv
// Shared types, mode codes and pattern tables of the LED pattern sequencer.
// Used by led_seq_core and led_pattern_sequencer_top; depends on nothing.
package led_seq_pkg;

   // Mode codes as carried on the active_mode field
   localparam logic [2:0] MODE_IDLE      = 3'd0;
   localparam logic [2:0] MODE_ALT       = 3'd1;
   localparam logic [2:0] MODE_FILL_LOW  = 3'd2;
   localparam logic [2:0] MODE_FILL_HIGH = 3'd3;
   localparam logic [2:0] MODE_BOUNCE    = 3'd4;

   localparam logic [15:0] TICK_PERIOD_RESET = 16'd30;
   localparam logic [7:0]  PORT_ALL_OFF      = 8'hff;
   localparam logic [7:0]  PORT_ALT_EVEN     = 8'h55;
   localparam logic [7:0]  PORT_ALT_ODD      = 8'haa;

   // Last step index of each table mode
   localparam logic [3:0] FILL_LAST_STEP   = 4'd8;
   localparam logic [3:0] BOUNCE_LAST_STEP = 4'd14;

   // Result of one request as seen on the response channel
   typedef struct packed {
      logic [2:0] active_mode;
      logic [7:0] led_port;
   } result_type;

   // Outcome of one tick on a mode's counter
   typedef struct packed {
      logic        elapsed;
      logic [15:0] count;
   } tick_type;

   // Advance a tick counter; a period has elapsed when it reaches the period
   function automatic tick_type tick_advance(input logic [15:0] count,
                                             input logic [15:0] period);
      tick_type   res;
      logic [15:0] nxt;
      nxt = count + 16'd1;
      if (nxt >= period) begin
         res.elapsed = 1'b1;
         res.count   = '0;
      end else begin
         res.elapsed = 1'b0;
         res.count   = nxt;
      end
      return res;
   endfunction

   // Step to the next table entry, wrapping after the last one
   function automatic logic [3:0] step_advance(input logic [3:0] step,
                                               input logic [3:0] last);
      return (step >= last) ? 4'd0 : step + 4'd1;
   endfunction

   // Fill from bit 0 upward
   function automatic logic [7:0] fill_low_entry(input logic [3:0] step);
      logic [7:0] val;
      unique case (step)
         4'd1:    val = 8'hfe;
         4'd2:    val = 8'hfc;
         4'd3:    val = 8'hf8;
         4'd4:    val = 8'hf0;
         4'd5:    val = 8'he0;
         4'd6:    val = 8'hc0;
         4'd7:    val = 8'h80;
         4'd8:    val = 8'h00;
         default: val = 8'hff;
      endcase
      return val;
   endfunction

   // Fill from bit 7 downward
   function automatic logic [7:0] fill_high_entry(input logic [3:0] step);
      logic [7:0] val;
      unique case (step)
         4'd1:    val = 8'h7f;
         4'd2:    val = 8'h3f;
         4'd3:    val = 8'h1f;
         4'd4:    val = 8'h0f;
         4'd5:    val = 8'h07;
         4'd6:    val = 8'h03;
         4'd7:    val = 8'h01;
         4'd8:    val = 8'h00;
         default: val = 8'hff;
      endcase
      return val;
   endfunction

   // Single lit LED running up and back down
   function automatic logic [7:0] bounce_entry(input logic [3:0] step);
      logic [7:0] val;
      unique case (step)
         4'd0:    val = 8'hfe;
         4'd1:    val = 8'hfd;
         4'd2:    val = 8'hfb;
         4'd3:    val = 8'hf7;
         4'd4:    val = 8'hef;
         4'd5:    val = 8'hdf;
         4'd6:    val = 8'hbf;
         4'd7:    val = 8'h7f;
         4'd8:    val = 8'hbf;
         4'd9:    val = 8'hdf;
         4'd10:   val = 8'hef;
         4'd11:   val = 8'hf7;
         4'd12:   val = 8'hfb;
         4'd13:   val = 8'hfd;
         4'd14:   val = 8'hfe;
         default: val = 8'hff;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/led_seq_core.sv
// Mode, counter and port state of the LED pattern sequencer with its update logic.
// Depends on led_seq_pkg.
module led_seq_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,      // commit one request
   input  logic                    key_pressed,
   input  logic [15:0]             tick_period,
   output led_seq_pkg::result_type result_next   // state after this request
);

   logic [2:0]  mode_ff,            mode_in;
   logic [7:0]  port_ff,            port_in;
   logic [15:0] alt_count_ff,       alt_count_in;
   logic        alt_phase_ff,       alt_phase_in;
   logic [15:0] low_count_ff,       low_count_in;
   logic [3:0]  low_step_ff,        low_step_in;
   logic [15:0] high_count_ff,      high_count_in;
   logic [3:0]  high_step_ff,       high_step_in;
   logic [15:0] bounce_count_ff,    bounce_count_in;
   logic [3:0]  bounce_step_ff,     bounce_step_in;

   led_seq_pkg::tick_type tick;

   // Next state for one request
   always_comb begin
      mode_in         = mode_ff;
      port_in         = port_ff;
      alt_count_in    = alt_count_ff;
      alt_phase_in    = alt_phase_ff;
      low_count_in    = low_count_ff;
      low_step_in     = low_step_ff;
      high_count_in   = high_count_ff;
      high_step_in    = high_step_ff;
      bounce_count_in = bounce_count_ff;
      bounce_step_in  = bounce_step_ff;
      tick            = '0;

      // advance the mode; on the wrap blank the port first
      if (key_pressed) begin
         if (mode_ff >= led_seq_pkg::MODE_BOUNCE) begin
            mode_in = led_seq_pkg::MODE_ALT;
            port_in = led_seq_pkg::PORT_ALL_OFF;
         end else begin
            mode_in = mode_ff + 3'd1;
         end
      end

      // run only the active mode's counter
      unique case (mode_in)
         led_seq_pkg::MODE_ALT: begin
            tick         = led_seq_pkg::tick_advance(alt_count_ff, tick_period);
            alt_count_in = tick.count;
            alt_phase_in = alt_phase_ff ^ tick.elapsed;
            port_in      = alt_phase_in ? led_seq_pkg::PORT_ALT_ODD
                                        : led_seq_pkg::PORT_ALT_EVEN;
         end
         led_seq_pkg::MODE_FILL_LOW: begin
            tick         = led_seq_pkg::tick_advance(low_count_ff, tick_period);
            low_count_in = tick.count;
            if (tick.elapsed) begin
               low_step_in = led_seq_pkg::step_advance(low_step_ff,
                                                       led_seq_pkg::FILL_LAST_STEP);
            end
            if (low_step_in != 4'd0) begin
               port_in = led_seq_pkg::fill_low_entry(low_step_in);
            end
         end
         led_seq_pkg::MODE_FILL_HIGH: begin
            tick          = led_seq_pkg::tick_advance(high_count_ff, tick_period);
            high_count_in = tick.count;
            if (tick.elapsed) begin
               high_step_in = led_seq_pkg::step_advance(high_step_ff,
                                                        led_seq_pkg::FILL_LAST_STEP);
            end
            if (high_step_in != 4'd0) begin
               port_in = led_seq_pkg::fill_high_entry(high_step_in);
            end
         end
         led_seq_pkg::MODE_BOUNCE: begin
            tick            = led_seq_pkg::tick_advance(bounce_count_ff, tick_period);
            bounce_count_in = tick.count;
            if (tick.elapsed) begin
               bounce_step_in = led_seq_pkg::step_advance(bounce_step_ff,
                                                          led_seq_pkg::BOUNCE_LAST_STEP);
            end
            if (bounce_step_in != 4'd0) begin
               port_in = led_seq_pkg::bounce_entry(bounce_step_in);
            end
         end
         default: begin
            // idle: hold everything
         end
      endcase
   end

   assign result_next.active_mode = mode_in;
   assign result_next.led_port    = port_in;

   // Commit the state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= led_seq_pkg::MODE_IDLE;
         port_ff         <= led_seq_pkg::PORT_ALL_OFF;
         alt_count_ff    <= '0;
         alt_phase_ff    <= 1'b0;
         low_count_ff    <= '0;
         low_step_ff     <= '0;
         high_count_ff   <= '0;
         high_step_ff    <= '0;
         bounce_count_ff <= '0;
         bounce_step_ff  <= '0;
      end else if (step_en) begin
         mode_ff         <= mode_in;
         port_ff         <= port_in;
         alt_count_ff    <= alt_count_in;
         alt_phase_ff    <= alt_phase_in;
         low_count_ff    <= low_count_in;
         low_step_ff     <= low_step_in;
         high_count_ff   <= high_count_in;
         high_step_ff    <= high_step_in;
         bounce_count_ff <= bounce_count_in;
         bounce_step_ff  <= bounce_step_in;
      end
   end

endmodule

// File: rtl/core/led_pattern_sequencer_top.sv
// Top level of the LED pattern sequencer: request register, result register,
// tick period register. Depends on led_seq_pkg and led_seq_core.
//
// Usage: each request on req_ is one timer tick carrying the key-press flag.
// Every request gives exactly one response on rsp_ with the active-low LED
// port byte and the mode after that tick. tick_period is written on csr_,
// which is always ready; write it only while no request is in flight.
// A request is held in the request register; its state update and response
// are committed together, into the core state and the result register, when
// that register is free or being drained. Throughput: one request per cycle
// while rsp_tready is high, set by the counter and table update in led_seq_core.
// Stalls: when rsp_tready is low the response holds; one further request
// may wait in the request register, after which req_tready drops.
// Reset: synchronous, clears both stages, mode 0 with all LEDs off, all
// counters and steps to 0 and tick_period to 30.
module led_pattern_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [0] key_pressed, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] led_port, [10:8] active_mode, [15:11] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data      // tick_period
);

   logic        req_valid_ff;
   logic        req_key_ff;
   logic        rsp_valid_ff;
   logic        advance;
   logic [15:0] tick_period_ff;

   led_seq_pkg::result_type result_next;
   led_seq_pkg::result_type rsp_data_ff;

   // Move forward when the result register is free or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // Hold the tick period
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= led_seq_pkg::TICK_PERIOD_RESET;
      end else if (csr_valid) begin
         tick_period_ff <= csr_data;
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         req_key_ff <= req_tdata[0];
      end
   end

   led_seq_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (req_valid_ff && advance),
      .key_pressed (req_key_ff),
      .tick_period (tick_period_ff),
      .result_next (result_next)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid_ff) begin
         rsp_data_ff <= result_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.active_mode, rsp_data_ff.led_port};

endmodule

// File: rtl/core/led_seq_checker.sv
// Port-level checks of the LED pattern sequencer, bound to the top level.
// Depends on led_pattern_sequencer_top's port list only.
module led_seq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // Stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Nothing comes out straight after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response right after reset");

   // Mode never beyond the last pattern, and bits [15:11] zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:8] <= 3'd4 && rsp_tdata[15:11] == 5'd0)
      else $error("mode out of range");

   // Idle mode leaves all LEDs off
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10:8] == 3'd0 |-> rsp_tdata[7:0] == 8'hff)
      else $error("idle mode lit an LED");

   // Alternating mode shows only its two patterns
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10:8] == 3'd1
         |-> rsp_tdata[7:0] == 8'h55 || rsp_tdata[7:0] == 8'haa)
      else $error("bad alternating pattern");

endmodule

bind led_pattern_sequencer_top led_seq_checker u_led_seq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for led_pattern_sequencer_top: predicts the LED port and
// mode for every tick request and checks each response. Depends on led_seq_pkg.
module tb_top;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_OFF_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [0] key_pressed, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [7:0] led_port, [10:8] active_mode, [15:11] zero
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = led_seq_pkg::TICK_PERIOD_RESET;

   led_pattern_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Tick requests waiting to be driven and LED results still due
   bit                      key_presses [$];
   led_seq_pkg::result_type led_due [$];
   int         ticks_queued = 0;
   int         ticks_checked = 0;
   int         error_count = 0;
   int         cycle_count = 0;

   // Idling controls, owned by the stimulus process
   bit         sender_idles = 1'b0;
   bit         receiver_idles = 1'b0;
   int         holds_asked = 0;
   int         holds_done = 0;
   int         gap_left = 0;
   int         stall_left = 0;

   // Predicted sequencer state
   logic [15:0] tick_period = led_seq_pkg::TICK_PERIOD_RESET;
   logic [2:0]  cur_mode = led_seq_pkg::MODE_IDLE;
   logic [7:0]  cur_port = led_seq_pkg::PORT_ALL_OFF;
   logic        alt_phase = 1'b0;
   logic [15:0] mode_count [1:4] = '{16'd0, 16'd0, 16'd0, 16'd0};
   logic [3:0]  mode_step [2:4] = '{4'd0, 4'd0, 4'd0};

   logic [7:0] fill_up_bytes [0:8] =
      '{8'hff, 8'hfe, 8'hfc, 8'hf8, 8'hf0, 8'he0, 8'hc0, 8'h80, 8'h00};
   logic [7:0] fill_down_bytes [0:8] =
      '{8'hff, 8'h7f, 8'h3f, 8'h1f, 8'h0f, 8'h07, 8'h03, 8'h01, 8'h00};
   logic [7:0] bounce_bytes [0:14] =
      '{8'hfe, 8'hfd, 8'hfb, 8'hf7, 8'hef, 8'hdf, 8'hbf, 8'h7f,
        8'hbf, 8'hdf, 8'hef, 8'hf7, 8'hfb, 8'hfd, 8'hfe};

   initial begin
      forever #5 clock = ~clock;
   end

   // Count one tick of a mode; report whether its period has run out
   function automatic bit period_elapsed(input logic [2:0] m);
      logic [15:0] nxt;
      nxt = mode_count[m] + 16'd1;
      if (nxt >= tick_period) begin
         mode_count[m] = '0;
         return 1'b1;
      end
      mode_count[m] = nxt;
      return 1'b0;
   endfunction

   function automatic logic [7:0] pattern_byte(input logic [2:0] m, input logic [3:0] s);
      case (m)
         led_seq_pkg::MODE_FILL_LOW:  return fill_up_bytes[s];
         led_seq_pkg::MODE_FILL_HIGH: return fill_down_bytes[s];
         default:                     return bounce_bytes[s];
      endcase
   endfunction

   // Advance the predicted sequencer by one tick and queue the LED result
   function automatic void sequence_tick(input logic key);
      led_seq_pkg::result_type res;
      logic [3:0] last;
      if (key) begin
         if (cur_mode == led_seq_pkg::MODE_BOUNCE) begin
            cur_mode = led_seq_pkg::MODE_ALT;
            cur_port = led_seq_pkg::PORT_ALL_OFF;
         end else begin
            cur_mode = cur_mode + 3'd1;
         end
      end
      if (cur_mode == led_seq_pkg::MODE_ALT) begin
         if (period_elapsed(cur_mode))
            alt_phase = ~alt_phase;
         cur_port = alt_phase ? led_seq_pkg::PORT_ALT_ODD : led_seq_pkg::PORT_ALT_EVEN;
      end else if (cur_mode != led_seq_pkg::MODE_IDLE) begin
         last = (cur_mode == led_seq_pkg::MODE_BOUNCE) ? led_seq_pkg::BOUNCE_LAST_STEP
                                                       : led_seq_pkg::FILL_LAST_STEP;
         if (period_elapsed(cur_mode))
            mode_step[cur_mode] = (mode_step[cur_mode] >= last) ? 4'd0
                                                                : mode_step[cur_mode] + 4'd1;
         if (mode_step[cur_mode] != 4'd0)
            cur_port = pattern_byte(cur_mode, mode_step[cur_mode]);
      end
      res.active_mode = cur_mode;
      res.led_port    = cur_port;
      led_due.push_back(res);
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drive tick requests; predict each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            sequence_tick(req_tdata[0]);
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (key_presses.size() != 0) begin
               req_tdata  <= {7'd0, key_presses.pop_front()};
               req_tvalid <= 1'b1;
               gap_left = sender_idles ? pick_gap() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver readiness: long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (holds_done != holds_asked) begin
         holds_done = holds_asked;
         stall_left = HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 99) < 30) begin
         stall_left = pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check each response against the oldest predicted result
   always @(posedge clock) begin
      led_seq_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (led_due.size() == 0) begin
            $error("unexpected response: led_port %02h active_mode %0d",
                   rsp_tdata[7:0], rsp_tdata[10:8]);
            error_count++;
         end else begin
            want = led_due.pop_front();
            if (rsp_tdata[7:0] !== want.led_port) begin
               $error("led_port: expected %02h, got %02h", want.led_port, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[10:8] !== want.active_mode) begin
               $error("active_mode: expected %0d, got %0d",
                      want.active_mode, rsp_tdata[10:8]);
               error_count++;
            end
            ticks_checked++;
         end
      end
   end

   // Guard against a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic set_period(input logic [15:0] p);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= p;
      do @(posedge clock); while (!csr_ready);
      tick_period = p;
      csr_valid <= 1'b0;
   endtask

   task automatic queue_ticks(input int count, input int press_pct);
      repeat (count) begin
         key_presses.push_back($urandom_range(0, 99) < press_pct);
         ticks_queued++;
      end
   endtask

   task automatic queue_press();
      key_presses.push_back(1'b1);
      ticks_queued++;
   endtask

   // Wait until every queued tick has been answered, then let the pipe drain
   task automatic settle();
      do @(posedge clock); while (ticks_checked < ticks_queued);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int period;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Idle mode after reset, then into the alternating pattern
      queue_ticks(2, 0);
      queue_press();
      settle();

      // Shortest period: walk through every mode and the wrap back to mode 1
      set_period(16'd1);
      queue_ticks(1, 0);
      queue_press();
      queue_ticks(2, 0);
      queue_press();
      queue_ticks(1, 0);
      queue_press();
      queue_ticks(2, 0);
      queue_press();
      settle();

      // Period of zero steps on every tick
      set_period(16'd0);
      queue_press();
      queue_ticks(2, 0);
      settle();

      // Longest period
      set_period(16'hffff);
      queue_ticks(2, 0);
      settle();

      // Lower the period below a running counter
      set_period(16'd40);
      queue_ticks(6, 0);
      settle();
      set_period(16'd3);
      queue_ticks(2, 0);
      settle();

      // Random phases with varied periods, press rates and idling
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 5)
            period = $urandom_range(1, 65535);
         else if (ph == 9)
            period = 0;
         else
            period = $urandom_range(1, 6);
         set_period(period[15:0]);
         sender_idles   <= (ph % 4) != 0;
         receiver_idles <= (ph % 4) > 1;
         queue_ticks(145, (ph == 7) ? 50 : $urandom_range(2, 20));
         // Hold the receiver off while requests keep coming
         if (ph == 3 || ph == 8)
            holds_asked <= holds_asked + 1;
         settle();
      end

      repeat (10) @(posedge clock);
      if (led_due.size() != 0) begin
         $error("%0d results never arrived", led_due.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
